FILE: design/ffha_pkg.sv
// Shared types, constants and status codes for the first-fit heap allocator.
// No dependencies; every other design file but ffha_ram refers to it by scoped names.
`timescale 1ns / 1ps

package ffha_pkg;

  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 26;
  localparam int NEED_W       = SIZE_W + 1;
  localparam int SUM_W        = ADDR_W + 2;
  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int HEADER_BYTES = 16;
  // alignment must be a power of two
  localparam int SIZE_ALIGN   = 4;
  localparam int ALIGN_LG     = $clog2(SIZE_ALIGN);
  localparam logic [ADDR_W-1:0] SIZE_CAP = 32'h0200_0000;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_BIG     = 3'd2;
  localparam logic [2:0] ST_NOSPACE = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] result_address;
    logic [2:0]        status;
  } res_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             eq;
    logic             gt;
  } alu_out_t;

endpackage

FILE: design/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/ffha_alu.sv
// Shared adder and comparator of the allocator sequencer.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_alu (
  input  logic [ffha_pkg::SUM_W-1:0] a,
  input  logic [ffha_pkg::SUM_W-1:0] b,
  input  logic [ffha_pkg::SUM_W-1:0] cmp,
  output ffha_pkg::alu_out_t         res
);

  logic [ffha_pkg::SUM_W-1:0] sum;

  assign sum     = a + b;
  assign res.sum = sum;
  assign res.eq  = (sum[ffha_pkg::ADDR_W-1:0] == cmp[ffha_pkg::ADDR_W-1:0]);
  assign res.gt  = (sum > cmp);

endmodule

FILE: design/ffha_seq.sv
// Sequencer of the allocator: block table walk, split with shift, append at the break.
// Depends on ffha_pkg, ffha_ram and ffha_alu.
`timescale 1ns / 1ps

module ffha_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  ffha_pkg::req_t                req,
  input  logic [ffha_pkg::ADDR_W-1:0]   heap_base,
  input  logic [ffha_pkg::ADDR_W-1:0]   heap_limit,
  input  logic                          res_take,
  output logic                          busy,
  output ffha_pkg::res_t                res
);

  localparam int AW = ffha_pkg::ADDR_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int NW = ffha_pkg::NEED_W;
  localparam int XW = ffha_pkg::SUM_W;
  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SPLIT  = 4'd3;
  localparam logic [3:0] S_SHIFT  = 4'd4;
  localparam logic [3:0] S_INSERT = 4'd5;
  localparam logic [3:0] S_APP1   = 4'd6;
  localparam logic [3:0] S_APP2   = 4'd7;
  localparam logic [3:0] S_APP3   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic          mode_r, mode_nxt;
  logic [SW-1:0] req_r, req_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [SW-1:0] need_r, need_nxt;
  logic [NW-1:0] need_hdr_r, need_hdr_nxt;
  logic [NW-1:0] need_hm1_r, need_hm1_nxt;
  logic [AW-1:0] base_hdr_r, base_hdr_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] brk_r, brk_nxt;
  logic [AW-1:0] ent_off_r, ent_off_nxt;
  logic [SW-1:0] ent_size_r, ent_size_nxt;
  logic [AW-1:0] rest_off_r, rest_off_nxt;
  logic [SW-1:0] rest_size_r, rest_size_nxt;
  logic [AW:0]   nbm1_r, nbm1_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic [2:0]    status_r, status_nxt;

  logic [NW-1:0] need_raw;
  logic          we;
  logic [IW-1:0] waddr;
  ffha_pkg::entry_t wdata;
  logic [ffha_pkg::ENTRY_W-1:0] rdata_raw;
  ffha_pkg::entry_t ent;
  logic [XW-1:0] alu_a, alu_b, alu_cmp;
  ffha_pkg::alu_out_t alu;
  logic          hit, split, last_ent;

  ffha_ram #(
    .WIDTH(ffha_pkg::ENTRY_W),
    .DEPTH(ffha_pkg::MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_nxt),
    .rdata(rdata_raw)
  );

  ffha_alu u_alu (
    .a  (alu_a),
    .b  (alu_b),
    .cmp(alu_cmp),
    .res(alu)
  );

  assign ent = ffha_pkg::entry_t'(rdata_raw);

  // round up to the alignment
  assign need_raw = (({1'b0, req.req_size} + NW'(ffha_pkg::SIZE_ALIGN - 1)) >> ffha_pkg::ALIGN_LG)
                    << ffha_pkg::ALIGN_LG;

  assign hit = (mode_r == ffha_pkg::MODE_FREE) ? alu.eq
                                               : (ent.free && (ent.size >= need_r));
  assign split = ({1'b0, ent.size} > need_hdr_r) &&
                 (count_r != CW'(ffha_pkg::MAX_BLOCKS));
  assign last_ent = ((CW'(idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    need_nxt      = need_r;
    need_hdr_nxt  = need_hdr_r;
    need_hm1_nxt  = need_hm1_r;
    base_hdr_nxt  = base_hdr_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    brk_nxt       = brk_r;
    ent_off_nxt   = ent_off_r;
    ent_size_nxt  = ent_size_r;
    rest_off_nxt  = rest_off_r;
    rest_size_nxt = rest_size_r;
    nbm1_nxt      = nbm1_r;
    res_addr_nxt  = res_addr_r;
    status_nxt    = status_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = '0;
    alu_a         = '0;
    alu_b         = '0;
    alu_cmp       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = req.mode;
          req_nxt   = req.req_size;
          addr_nxt  = req.free_address;
          need_nxt  = need_raw[SW-1:0];
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        alu_a        = {2'b0, heap_base};
        alu_b        = XW'(ffha_pkg::HEADER_BYTES);
        base_hdr_nxt = alu.sum[AW-1:0];
        need_hdr_nxt = {1'b0, need_r} + NW'(ffha_pkg::HEADER_BYTES);
        need_hm1_nxt = {1'b0, need_r} + NW'(ffha_pkg::HEADER_BYTES - 1);
        res_addr_nxt = '0;
        idx_nxt      = '0;
        if (mode_r == ffha_pkg::MODE_ALLOC) begin
          if (req_r == '0) begin
            status_nxt = ffha_pkg::ST_NULL;
            state_nxt  = S_FIN;
          end else if (AW'(req_r) >= ffha_pkg::SIZE_CAP) begin
            status_nxt = ffha_pkg::ST_BIG;
            state_nxt  = S_FIN;
          end else if (count_r == '0) begin
            state_nxt = S_APP1;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          if (addr_r == '0) begin
            status_nxt = ffha_pkg::ST_NULL;
            state_nxt  = S_FIN;
          end else if (count_r == '0) begin
            status_nxt = ffha_pkg::ST_UNKNOWN;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // one table entry per cycle; the read address runs one entry ahead
      S_SCAN: begin
        alu_a   = {2'b0, base_hdr_r};
        alu_b   = {2'b0, ent.offset};
        alu_cmp = {2'b0, addr_r};
        if (hit) begin
          hit_nxt    = idx_r;
          status_nxt = ffha_pkg::ST_OK;
          we         = 1'b1;
          waddr      = idx_r;
          if (mode_r == ffha_pkg::MODE_FREE) begin
            wdata        = '{offset: ent.offset, size: ent.size, free: 1'b1};
            res_addr_nxt = '0;
            state_nxt    = S_FIN;
          end else begin
            wdata        = '{offset: ent.offset, size: (split ? need_r : ent.size),
                             free: 1'b0};
            res_addr_nxt = alu.sum[AW-1:0];
            ent_off_nxt  = ent.offset;
            ent_size_nxt = ent.size;
            state_nxt    = split ? S_SPLIT : S_FIN;
          end
        end else if (last_ent) begin
          if (mode_r == ffha_pkg::MODE_FREE) begin
            status_nxt = ffha_pkg::ST_UNKNOWN;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_APP1;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      S_SPLIT: begin
        alu_a         = {2'b0, ent_off_r};
        alu_b         = XW'(need_hdr_r);
        rest_off_nxt  = alu.sum[AW-1:0];
        rest_size_nxt = SW'({1'b0, ent_size_r} - need_hdr_r);
        idx_nxt       = IW'(count_r - CW'(1));
        state_nxt     = ((CW'(hit_r) + CW'(1)) == count_r) ? S_INSERT : S_SHIFT;
      end

      // move entries up by one, top first
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_r + IW'(1);
        wdata = ent;
        if (idx_r == (hit_r + IW'(1))) begin
          state_nxt = S_INSERT;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end

      S_INSERT: begin
        we        = 1'b1;
        waddr     = hit_r + IW'(1);
        wdata     = '{offset: rest_off_r, size: rest_size_r, free: 1'b1};
        count_nxt = count_r + CW'(1);
        state_nxt = S_FIN;
      end

      S_APP1: begin
        alu_a    = {2'b0, brk_r};
        alu_b    = XW'(need_hm1_r);
        nbm1_nxt = alu.sum[AW:0];
        if (count_r == CW'(ffha_pkg::MAX_BLOCKS)) begin
          status_nxt = ffha_pkg::ST_NOSPACE;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_APP2;
        end
      end

      // last byte of the new block against the limit, new break against 32 bits
      S_APP2: begin
        alu_a   = {2'b0, heap_base};
        alu_b   = {1'b0, nbm1_r};
        alu_cmp = {2'b0, heap_limit};
        if (nbm1_r[AW] || (&nbm1_r[AW-1:0]) || alu.gt) begin
          status_nxt = ffha_pkg::ST_NOSPACE;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_APP3;
        end
      end

      S_APP3: begin
        alu_a        = {2'b0, base_hdr_r};
        alu_b        = {2'b0, brk_r};
        res_addr_nxt = alu.sum[AW-1:0];
        status_nxt   = ffha_pkg::ST_OK;
        we           = 1'b1;
        waddr        = count_r[IW-1:0];
        wdata        = '{offset: brk_r, size: need_r, free: 1'b0};
        brk_nxt      = nbm1_r[AW-1:0] + AW'(1);
        count_nxt    = count_r + CW'(1);
        state_nxt    = S_FIN;
      end

      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      brk_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      brk_r   <= brk_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    req_r       <= req_nxt;
    addr_r      <= addr_nxt;
    need_r      <= need_nxt;
    need_hdr_r  <= need_hdr_nxt;
    need_hm1_r  <= need_hm1_nxt;
    base_hdr_r  <= base_hdr_nxt;
    hit_r       <= hit_nxt;
    ent_off_r   <= ent_off_nxt;
    ent_size_r  <= ent_size_nxt;
    rest_off_r  <= rest_off_nxt;
    rest_size_r <= rest_size_nxt;
    nbm1_r      <= nbm1_nxt;
    res_addr_r  <= res_addr_nxt;
    status_r    <= status_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign res.done           = (state_r == S_FIN);
  assign res.result_address = res_addr_r;
  assign res.status         = status_r;

endmodule

FILE: design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: APB registers, channels, result register.
// Depends on ffha_pkg and ffha_seq (which holds ffha_ram and ffha_alu).
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_mode, in_req_size, in_free_address
//   out_     output     out_valid / out_stall out_result_address, out_status
//   apb      input      psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// A request with zero size, too large a size or a null free address is rejected before
// the table walk; otherwise the walk stops at the first matching entry, an allocation that
// splits a block then moves the entries above it up by one and inserts the remainder, and
// an allocation with no fit tries an append at the break. The walk takes one entry per cycle.
// Reset empties the table through its fill count; no clearing pass is needed.
// in_stall stays high while a request is in work; a result waits in the output
// register under out_stall while the next request is already taken.
`timescale 1ns / 1ps

module first_fit_heap_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [ffha_pkg::SIZE_W-1:0] in_req_size,
  input  logic [ffha_pkg::ADDR_W-1:0] in_free_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ffha_pkg::ADDR_W-1:0] out_result_address,
  output logic [2:0]                  out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  logic [ffha_pkg::ADDR_W-1:0] heap_base_r, heap_base_nxt;
  logic [ffha_pkg::ADDR_W-1:0] heap_limit_r, heap_limit_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ffha_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [2:0]                  out_status_r, out_status_nxt;

  logic           busy;
  logic           start;
  logic           res_take;
  logic           cfg_wr;
  ffha_pkg::req_t req;
  ffha_pkg::res_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    heap_base_nxt  = heap_base_r;
    heap_limit_nxt = heap_limit_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_BASE:  heap_base_nxt  = pwdata;
        REG_LIMIT: heap_limit_nxt = pwdata;
        default:   heap_base_nxt  = heap_base_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_LIMIT) ? heap_limit_r : heap_base_r;

  assign in_stall         = busy;
  assign start            = in_valid && !busy;
  assign req.mode         = in_mode;
  assign req.req_size     = in_req_size;
  assign req.free_address = in_free_address;

  // load the result once the output register is free or being emptied
  assign res_take = res.done && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = res.result_address;
      out_status_nxt = res.status;
    end
  end

  ffha_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .heap_base (heap_base_r),
    .heap_limit(heap_limit_r),
    .res_take  (res_take),
    .busy      (busy),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r  <= '0;
      heap_limit_r <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      heap_base_r  <= heap_base_nxt;
      heap_limit_r <= heap_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transaction was taken");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ffha_pkg::ST_UNKNOWN))
    else $error("status code out of range");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ffha_pkg::ST_OK)) |-> (out_result_address == '0))
    else $error("failed request returned an address");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_address)
                                 && $stable(out_status)))
    else $error("waiting result was overwritten");
`endif

endmodule

FILE: test/first_fit_heap_allocator_test.sv
// Self-checking testbench for first_fit_heap_allocator: random bursts of allocate and free
// requests, a shadow block table that predicts every result, and APB heap base/limit writes.
// Depends on ffha_pkg and the allocator RTL.
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;

  localparam int ADDR_W         = ffha_pkg::ADDR_W;
  localparam int SIZE_W         = ffha_pkg::SIZE_W;
  localparam int REG_HEAP_BASE  = 0;
  localparam int REG_HEAP_LIMIT = 1;
  localparam int QUIET_LIMIT    = 5000;
  localparam int END_PAUSE      = 200;

  typedef struct {
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] faddr;
  } heap_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [2:0]        status;
  } heap_result_t;

  typedef struct {
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } heap_block_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = ffha_pkg::MODE_ALLOC;
  logic [SIZE_W-1:0] in_req_size = '0;
  logic [ADDR_W-1:0] in_free_address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] out_result_address;
  logic [2:0]        out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_req_size(in_req_size), .in_free_address(in_free_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_address(out_result_address), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the allocator state
  heap_block_t       blk_tab[ffha_pkg::MAX_BLOCKS];
  int                blk_count = 0;
  logic [ADDR_W-1:0] heap_brk = '0;
  logic [ADDR_W-1:0] base_reg = '0;
  logic [ADDR_W-1:0] limit_reg = '1;

  heap_req_t    pending_requests[$];
  heap_result_t expected_results[$];
  heap_req_t    cur_request;
  heap_result_t got_expect;
  int           mismatch_count = 0;
  int           burst_left = 1;
  int           gap_left = 0;
  int           quiet_cycles = 0;
  int           stall_timer = 0;
  stall_kind_t  stall_kind = STALL_NONE;

  function automatic logic [ADDR_W-1:0] payload_of(input int i);
    return base_reg + blk_tab[i].offset + ADDR_W'(ffha_pkg::HEADER_BYTES);
  endfunction

  function automatic void predict_request(input heap_req_t r);
    heap_result_t res;
    logic [31:0]  need;
    logic [63:0]  new_brk;
    logic [63:0]  last_byte;
    int           hit;
    res.addr = '0;
    res.status = ffha_pkg::ST_OK;
    hit = -1;
    if (r.mode == ffha_pkg::MODE_FREE) begin
      if (r.faddr == '0) begin
        res.status = ffha_pkg::ST_NULL;
      end else begin
        for (int i = 0; i < blk_count; i++)
          if (hit < 0 && payload_of(i) == r.faddr) hit = i;
        if (hit < 0) res.status = ffha_pkg::ST_UNKNOWN;
        else blk_tab[hit].is_free = 1'b1;
      end
    end else if (r.size == '0) begin
      res.status = ffha_pkg::ST_NULL;
    end else if (32'(r.size) >= ffha_pkg::SIZE_CAP) begin
      res.status = ffha_pkg::ST_BIG;
    end else begin
      need = (32'(r.size) + 32'(ffha_pkg::SIZE_ALIGN - 1)) / 32'(ffha_pkg::SIZE_ALIGN)
             * 32'(ffha_pkg::SIZE_ALIGN);
      for (int i = 0; i < blk_count; i++)
        if (hit < 0 && blk_tab[i].is_free && 32'(blk_tab[i].size) >= need) hit = i;
      if (hit >= 0) begin
        blk_tab[hit].is_free = 1'b0;
        // split only while the table has a spare entry
        if (32'(blk_tab[hit].size) > need + 32'(ffha_pkg::HEADER_BYTES) &&
            blk_count < ffha_pkg::MAX_BLOCKS) begin
          for (int j = blk_count; j > hit + 1; j--) blk_tab[j] = blk_tab[j-1];
          blk_tab[hit+1].offset  = blk_tab[hit].offset + 32'(ffha_pkg::HEADER_BYTES) + need;
          blk_tab[hit+1].size    = SIZE_W'(32'(blk_tab[hit].size) - need
                                           - 32'(ffha_pkg::HEADER_BYTES));
          blk_tab[hit+1].is_free = 1'b1;
          blk_tab[hit].size      = SIZE_W'(need);
          blk_count++;
        end
        res.addr = payload_of(hit);
      end else if (blk_count >= ffha_pkg::MAX_BLOCKS) begin
        res.status = ffha_pkg::ST_NOSPACE;
      end else begin
        new_brk   = 64'(heap_brk) + 64'(ffha_pkg::HEADER_BYTES) + 64'(need);
        last_byte = 64'(base_reg) + new_brk - 64'd1;
        if (new_brk > 64'hFFFF_FFFF || last_byte > 64'(limit_reg)) begin
          res.status = ffha_pkg::ST_NOSPACE;
        end else begin
          blk_tab[blk_count].offset  = heap_brk;
          blk_tab[blk_count].size    = SIZE_W'(need);
          blk_tab[blk_count].is_free = 1'b0;
          res.addr = payload_of(blk_count);
          heap_brk = new_brk[31:0];
          blk_count++;
        end
      end
    end
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // request driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_request(cur_request);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        cur_request = pending_requests.pop_front();
        in_valid <= 1'b1;
        in_mode <= cur_request.mode;
        in_req_size <= cur_request.size;
        in_free_address <= cur_request.faddr;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall: switch between random patterns at regular intervals
  always @(posedge clk) begin
    stall_timer <= stall_timer + 1;
    if (stall_timer % 256 == 0) stall_kind <= stall_kind_t'($urandom_range(0, 3));
    case (stall_kind)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
      default:        out_stall <= (stall_timer % 7 < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: addr %h status %0d",
                                  out_result_address, out_status));
      end else begin
        got_expect = expected_results.pop_front();
        if (out_result_address !== got_expect.addr)
          report_mismatch($sformatf("result_address %h, expected %h",
                                    out_result_address, got_expect.addr));
        if (out_status !== got_expect.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_status, got_expect.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_HEAP_BASE) base_reg = value;
    else limit_reg = value;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic start_phase(input logic [31:0] base, input logic [31:0] limit);
    wait_drained();
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_HEAP_LIMIT, limit);
  endtask

  task automatic push_request(input logic mode, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] faddr);
    heap_req_t r;
    r.mode = mode;
    r.size = size;
    r.faddr = faddr;
    pending_requests.push_back(r);
  endtask

  task automatic push_random_request();
    heap_req_t r;
    int        pick;
    r.mode = ($urandom_range(0, 99) < 55) ? ffha_pkg::MODE_ALLOC : ffha_pkg::MODE_FREE;
    r.size = SIZE_W'($urandom);
    r.faddr = $urandom;
    pick = $urandom_range(0, 99);
    if (r.mode == ffha_pkg::MODE_ALLOC) begin
      if (pick < 4)       r.size = '0;
      else if (pick < 8)  r.size = SIZE_W'($urandom_range(32'h200_0000, 32'h3FF_FFFF));
      else if (pick < 12) r.size = SIZE_W'($urandom_range(1025, 32'h1FF_FFFF));
      else if (pick < 30) r.size = SIZE_W'($urandom_range(65, 1024));
      else                r.size = SIZE_W'($urandom_range(1, 64));
    end else if (blk_count > 0 && pick < 85) begin
      r.faddr = payload_of($urandom_range(0, blk_count - 1));
      // near misses of a live address, now and then the address itself
      if (pick >= 72) r.faddr = r.faddr + 32'($urandom_range(1, 8)) - 32'd4;
    end else if (pick < 92) begin
      r.faddr = '0;
    end
    pending_requests.push_back(r);
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      while (pending_requests.size() >= 2) @(negedge clk);
      push_random_request();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    start_phase(32'h0000_1000, 32'hFFFF_FFFF);
    push_request(ffha_pkg::MODE_ALLOC, '0, '1);
    push_request(ffha_pkg::MODE_ALLOC, '1, '0);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(ffha_pkg::SIZE_CAP), 32'h5555_5555);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(1), 32'hAAAA_AAAA);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(100), '0);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(ffha_pkg::SIZE_CAP - 1), '0);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(64), '0);
    push_request(ffha_pkg::MODE_FREE, '1, '0);
    push_request(ffha_pkg::MODE_FREE, '0, 32'h0000_1024);
    push_request(ffha_pkg::MODE_FREE, 26'h155_5555, 32'h0000_1024);  // free the same block twice
    push_request(ffha_pkg::MODE_FREE, '0, 32'h0000_1025);
    push_request(ffha_pkg::MODE_FREE, '0, 32'hFFFF_FFFF);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(20), '0);             // splits the freed block
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(64), '0);
    push_request(ffha_pkg::MODE_FREE, '0, 32'h0000_1010);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(3), '0);
    push_request(ffha_pkg::MODE_FREE, '0, 32'h0000_1048);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(48), '0);  // remainder of one header: no split
    push_request(ffha_pkg::MODE_FREE, '0, 32'h0000_1048);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(44), '0);
    push_request(ffha_pkg::MODE_ALLOC, SIZE_W'(2), '0);

    // tight limit: appends run out while splits keep filling the table
    start_phase(32'h0000_1000, 32'h0200_1400);
    run_random(420);
    // base at the top moves every block and blocks any append
    start_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(300);
    start_phase(32'h0000_0000, 32'hFFFF_FFFF);
    run_random(400);
    start_phase(32'h8000_0000, 32'h0000_0000);
    run_random(300);
    start_phase($urandom, $urandom | 32'h8000_0000);
    run_random(430);

    wait_drained();
    repeat (END_PAUSE) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
